### src/shc_pkg.sv
// Package for the square hash match counter: field widths, default sizes,
// function codes and the command/status structs between controller and datapath.
// No dependencies.
package shc_pkg;

  // Default sizes (powers of two)
  localparam int IMAGE_SIDE_DEF     = 256;
  localparam int QUERY_MAX_SIDE_DEF = 32;
  localparam int MAX_ENTRIES_DEF    = 4096;
  localparam int NUM_BUCKETS_DEF    = 512;
  localparam int PIXEL_BITS_DEF     = 8;

  // Item field widths
  localparam int FUNC_W   = 2;
  localparam int COORD_W  = 8;
  localparam int PIX_IN_W = 8;
  localparam int AVG_W    = 8;
  localparam int SIDE_W   = 6;
  localparam int COUNT_W  = 13;
  localparam int SLOT_W   = 12;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_IMG = 2'd0,
    FUNC_INSERT   = 2'd1,
    FUNC_LOAD_QRY = 2'd2,
    FUNC_QUERY    = 2'd3
  } func_e;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic clr_we;
    logic load_wr;
    logic ins_wr;
    logic ins_fin;
    logic set_full;
    logic head_to_e;
    logic ent_cap;
    logic follow_next;
    logic pix_step;
    logic cnt_inc;
    logic res_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic full;
    logic head_valid;
    logic eligible;
    logic side_zero;
    logic pix_eq;
    logic pix_last;
    logic next_valid;
    logic out_busy;
  } stat_t;

endpackage

### src/square_hash_match_counter.sv
// Top level of the square hash match counter: stream ports, controller and
// datapath. Depends on shc_pkg, shc_ctrl, shc_dp.
//
//  channel | dir | handshake                    | payload
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | func, row, col, pixel, average, side
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | match_count, entry_slot, table_full
//
// After reset a sweep clears every bucket head; no item is taken until it ends.
// A load writes one pixel when in range; an insert links a new entry into its
// bucket chain, or is refused when the table is full. A query reads the bucket
// head, then per chain entry checks the descriptor and compares up to side*side pixels.
// One item is in work at a time; a result waits in the output register and
// the next item is taken once it has been moved there.
module square_hash_match_counter
  import shc_pkg::*;
#(
  parameter int ImageSide    = IMAGE_SIDE_DEF,
  parameter int QueryMaxSide = QUERY_MAX_SIDE_DEF,
  parameter int MaxEntries   = MAX_ENTRIES_DEF,
  parameter int NumBuckets   = NUM_BUCKETS_DEF,
  parameter int PixelBits    = PIXEL_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // func[1:0], row[9:2], col[17:10], pixel[25:18], average[33:26], side[39:34]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // match_count[12:0], entry_slot[24:13], table_full[25], zeros[31:26]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  cmd_t  cmd;
  stat_t stat;

  logic [FUNC_W-1:0]   in_func;
  logic [COORD_W-1:0]  in_row, in_col;
  logic [PIX_IN_W-1:0] in_pixel;
  logic [AVG_W-1:0]    in_average;
  logic [SIDE_W-1:0]   in_side;

  assign {in_side, in_average, in_pixel, in_col, in_row, in_func} = s_axis_tdata;

  shc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_func_i  (in_func),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  shc_dp #(
    .ImageSide    (ImageSide),
    .QueryMaxSide (QueryMaxSide),
    .MaxEntries   (MaxEntries),
    .NumBuckets   (NumBuckets),
    .PixelBits    (PixelBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .func_i      (in_func),
    .row_i       (in_row),
    .col_i       (in_col),
    .pixel_i     (in_pixel),
    .average_i   (in_average),
    .side_i      (in_side),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

`ifndef NO_ASSERTIONS
  // One item in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item taken while another is in work");

  // A refused insert carries no slot and no count
  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[25] |-> m_axis_tdata[24:0] == '0)
    else $error("full result with nonzero fields");

  // Slot and count never come together
  a_slot_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[24:13] != '0) |-> m_axis_tdata[12:0] == '0)
    else $error("insert result with a match count");
`endif

endmodule

### src/shc_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module shc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AW   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/shc_dp.sv
// Datapath: item registers, image/query/bucket/entry RAMs, walk and pixel
// counters, result registers and the output register. Depends on shc_pkg, shc_ram.
module shc_dp
  import shc_pkg::*;
#(
  parameter int ImageSide    = IMAGE_SIDE_DEF,
  parameter int QueryMaxSide = QUERY_MAX_SIDE_DEF,
  parameter int MaxEntries   = MAX_ENTRIES_DEF,
  parameter int NumBuckets   = NUM_BUCKETS_DEF,
  parameter int PixelBits    = PIXEL_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic [FUNC_W-1:0]      func_i,
  input  logic [COORD_W-1:0]     row_i,
  input  logic [COORD_W-1:0]     col_i,
  input  logic [PIX_IN_W-1:0]    pixel_i,
  input  logic [AVG_W-1:0]       average_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  localparam int IW   = $clog2(ImageSide);
  localparam int QW   = $clog2(QueryMaxSide);
  localparam int EW   = $clog2(MaxEntries);
  localparam int BW   = $clog2(NumBuckets);
  localparam int CW   = ((IW > COORD_W) ? IW : COORD_W) + 1;
  localparam int QCW  = (QW > COORD_W) ? QW : COORD_W;
  localparam int SUMW = (BW > AVG_W + 1) ? BW : AVG_W + 1;
  localparam int DW   = SIDE_W + 2 * COORD_W;
  localparam int PAD_W = OUT_TDATA_W - COUNT_W - SLOT_W - 1;

  // Item registers
  func_e               func_q;
  logic [COORD_W-1:0]  row_q, col_q;
  logic [PIX_IN_W-1:0] pix_q;
  logic [AVG_W-1:0]    avg_q;
  logic [SIDE_W-1:0]   side_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      func_q <= func_e'(func_i);
      row_q  <= row_i;
      col_q  <= col_i;
      pix_q  <= pixel_i;
      avg_q  <= average_i;
      side_q <= side_i;
    end
  end

  // Bucket index
  logic [SUMW-1:0] sum;
  logic [BW-1:0]   bucket;
  assign sum    = SUMW'(avg_q) + SUMW'(side_q);
  assign bucket = sum[BW-1:0];

  // Control and walk registers
  logic [BW-1:0]     clr_q;
  logic [EW:0]       used_q;
  logic [EW-1:0]     e_q, nx_q;
  logic              nv_q;
  logic [COORD_W-1:0] r0_q, c0_q;
  logic [SIDE_W-1:0] f_q, c_q;
  logic [EW:0]       res_cnt_q;
  logic [EW-1:0]     res_slot_q;
  logic              res_full_q;

  logic [EW-1:0] new_e;
  assign new_e = used_q[EW-1:0];

  // RAM wires
  logic [EW:0]     head_rdata, head_wdata;
  logic [BW-1:0]   head_waddr;
  logic            head_we;
  logic [EW-1:0]   tail_rdata;
  logic [DW-1:0]   desc_rdata;
  logic [EW:0]     next_rdata, next_wdata;
  logic [EW-1:0]   next_waddr;
  logic            next_we;
  logic [PixelBits-1:0] img_rdata, qry_rdata, pix_store;
  logic [PixelBits+PIX_IN_W-1:0] pix_x;

  assign pix_x     = (PixelBits + PIX_IN_W)'(pix_q);
  assign pix_store = pix_x[PixelBits-1:0];

  // Load addresses and range checks
  logic [CW-1:0]  row_x, col_x;
  logic [QCW-1:0] qrow_x, qcol_x;
  logic           img_in_range, qry_in_range, img_we, qry_we;

  assign row_x  = CW'(row_q);
  assign col_x  = CW'(col_q);
  assign qrow_x = QCW'(row_q);
  assign qcol_x = QCW'(col_q);
  assign img_in_range = (row_x < CW'(ImageSide)) && (col_x < CW'(ImageSide));
  assign qry_in_range = (qrow_x < QCW'(QueryMaxSide)) && (qcol_x < QCW'(QueryMaxSide));
  assign img_we = cmd_i.load_wr && (func_q == FUNC_LOAD_IMG) && img_in_range;
  assign qry_we = cmd_i.load_wr && (func_q == FUNC_LOAD_QRY) && qry_in_range;

  // Pixel read addresses during compare
  logic [CW-1:0]  rsum, csum;
  logic [QCW-1:0] qf_x, qc_x;
  assign rsum = CW'(r0_q) + CW'(f_q);
  assign csum = CW'(c0_q) + CW'(c_q);
  assign qf_x = QCW'(f_q);
  assign qc_x = QCW'(c_q);

  shc_ram #(.Width(PixelBits), .Depth(ImageSide * ImageSide)) u_img (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .waddr_i ({row_x[IW-1:0], col_x[IW-1:0]}),
    .wdata_i (pix_store),
    .raddr_i ({rsum[IW-1:0], csum[IW-1:0]}),
    .rdata_o (img_rdata)
  );

  shc_ram #(.Width(PixelBits), .Depth(QueryMaxSide * QueryMaxSide)) u_qry (
    .clk_i   (clk_i),
    .we_i    (qry_we),
    .waddr_i ({qrow_x[QW-1:0], qcol_x[QW-1:0]}),
    .wdata_i (pix_store),
    .raddr_i ({qf_x[QW-1:0], qc_x[QW-1:0]}),
    .rdata_o (qry_rdata)
  );

  // Bucket head: {valid, entry}; cleared by the sweep after reset
  assign head_we    = cmd_i.clr_we || (cmd_i.ins_wr && !head_rdata[EW]);
  assign head_waddr = cmd_i.clr_we ? clr_q : bucket;
  assign head_wdata = cmd_i.clr_we ? '0 : {1'b1, new_e};

  shc_ram #(.Width(EW + 1), .Depth(NumBuckets)) u_head (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (bucket),
    .rdata_o (head_rdata)
  );

  shc_ram #(.Width(EW), .Depth(NumBuckets)) u_tail (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins_wr),
    .waddr_i (bucket),
    .wdata_i (new_e),
    .raddr_i (bucket),
    .rdata_o (tail_rdata)
  );

  // Descriptor: {side, row, col}
  shc_ram #(.Width(DW), .Depth(MaxEntries)) u_desc (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ins_wr),
    .waddr_i (new_e),
    .wdata_i ({side_q, row_q, col_q}),
    .raddr_i (e_q),
    .rdata_o (desc_rdata)
  );

  // Next link: {valid, entry}; old tail linked first, new entry terminated after
  assign next_we    = (cmd_i.ins_wr && head_rdata[EW]) || cmd_i.ins_fin;
  assign next_waddr = cmd_i.ins_fin ? new_e : tail_rdata;
  assign next_wdata = cmd_i.ins_fin ? '0 : {1'b1, new_e};

  shc_ram #(.Width(EW + 1), .Depth(MaxEntries)) u_next (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (e_q),
    .rdata_o (next_rdata)
  );

  // Entry checks on fresh descriptor data
  logic [SIDE_W-1:0]  d_side;
  logic [COORD_W-1:0] d_row, d_col;
  logic [SIDE_W-1:0]  side_m1;
  assign {d_side, d_row, d_col} = desc_rdata;
  assign side_m1 = side_q - 1'b1;

  assign stat_o.clr_last   = &clr_q;
  assign stat_o.full       = used_q >= (EW + 1)'(MaxEntries);
  assign stat_o.head_valid = head_rdata[EW];
  assign stat_o.eligible   = (d_side == side_q)
                          && (CW'(side_q) <= CW'(QueryMaxSide))
                          && (CW'(d_row) + CW'(side_q) <= CW'(ImageSide))
                          && (CW'(d_col) + CW'(side_q) <= CW'(ImageSide));
  assign stat_o.side_zero  = (side_q == '0);
  assign stat_o.pix_eq     = (img_rdata == qry_rdata);
  assign stat_o.pix_last   = (f_q == side_m1) && (c_q == side_m1);
  assign stat_o.next_valid = nv_q;
  assign stat_o.out_busy   = out_valid_o && !out_ready_i;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      used_q <= '0;
    end else begin
      if (cmd_i.clr_we) clr_q <= clr_q + 1'b1;
      if (cmd_i.ins_fin) used_q <= used_q + 1'b1;
    end
  end

  // Walk, counters and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.head_to_e)   e_q <= head_rdata[EW-1:0];
    if (cmd_i.follow_next) e_q <= nx_q;
    if (cmd_i.ent_cap) begin
      r0_q <= d_row;
      c0_q <= d_col;
      nx_q <= next_rdata[EW-1:0];
      nv_q <= next_rdata[EW];
      f_q  <= '0;
      c_q  <= '0;
    end else if (cmd_i.pix_step) begin
      if (c_q == side_m1) begin
        c_q <= '0;
        f_q <= f_q + 1'b1;
      end else begin
        c_q <= c_q + 1'b1;
      end
    end
    if (cmd_i.load_item) begin
      res_cnt_q  <= '0;
      res_slot_q <= '0;
      res_full_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_inc)  res_cnt_q  <= res_cnt_q + 1'b1;
      if (cmd_i.ins_fin)  res_slot_q <= new_e;
      if (cmd_i.set_full) res_full_q <= 1'b1;
    end
  end

  // Output register
  logic [EW+COUNT_W:0]    cnt_x;
  logic [EW+SLOT_W-1:0]   slot_x;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  assign cnt_x  = {{COUNT_W{1'b0}}, res_cnt_q};
  assign slot_x = {{SLOT_W{1'b0}}, res_slot_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_data_q <= {{PAD_W{1'b0}}, res_full_q, slot_x[SLOT_W-1:0], cnt_x[COUNT_W-1:0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### src/shc_ctrl.sv
// Controller state machine: clearing sweep, item dispatch, insert sequence,
// chain walk and pixel compare loop. Depends on shc_pkg.
module shc_ctrl
  import shc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [FUNC_W-1:0] in_func_i,
  input  stat_t             stat_i,
  output cmd_t              cmd_o
);

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_LOAD     = 4'd2;
  localparam logic [3:0] S_INS_RD   = 4'd3;
  localparam logic [3:0] S_INS_WR   = 4'd4;
  localparam logic [3:0] S_INS_FIN  = 4'd5;
  localparam logic [3:0] S_HEAD_RD  = 4'd6;
  localparam logic [3:0] S_HEAD     = 4'd7;
  localparam logic [3:0] S_ENT_RD   = 4'd8;
  localparam logic [3:0] S_ENT      = 4'd9;
  localparam logic [3:0] S_PIX_RD   = 4'd10;
  localparam logic [3:0] S_PIX_CMP  = 4'd11;
  localparam logic [3:0] S_NEXT     = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_we = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          case (func_e'(in_func_i))
            FUNC_INSERT: state_d = S_INS_RD;
            FUNC_QUERY:  state_d = S_HEAD_RD;
            default:     state_d = S_LOAD;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load_wr = 1'b1;
        state_d = S_DONE;
      end
      S_INS_RD: begin
        if (stat_i.full) begin
          cmd_o.set_full = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.ins_wr = 1'b1;
        state_d = S_INS_FIN;
      end
      S_INS_FIN: begin
        cmd_o.ins_fin = 1'b1;
        state_d = S_DONE;
      end
      S_HEAD_RD: state_d = S_HEAD;
      S_HEAD: begin
        if (stat_i.head_valid) begin
          cmd_o.head_to_e = 1'b1;
          state_d = S_ENT_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_ENT_RD: state_d = S_ENT;
      S_ENT: begin
        cmd_o.ent_cap = 1'b1;
        if (stat_i.eligible && stat_i.side_zero) begin
          cmd_o.cnt_inc = 1'b1;
          state_d = S_NEXT;
        end else if (stat_i.eligible) begin
          state_d = S_PIX_RD;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_PIX_RD: state_d = S_PIX_CMP;
      S_PIX_CMP: begin
        if (!stat_i.pix_eq) begin
          state_d = S_NEXT;
        end else if (stat_i.pix_last) begin
          cmd_o.cnt_inc = 1'b1;
          state_d = S_NEXT;
        end else begin
          cmd_o.pix_step = 1'b1;
          state_d = S_PIX_RD;
        end
      end
      S_NEXT: begin
        if (stat_i.next_valid) begin
          cmd_o.follow_next = 1'b1;
          state_d = S_ENT_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
